@@ sv/stes_pkg.sv @@
`timescale 1ns / 1ps
package stes_pkg;

  localparam int TABLE_BITS = 6;
  localparam int POLY_TERMS = 6;
  localparam int MAX_TERMS  = 8;
  localparam int TAB_N      = 1 << TABLE_BITS;
  localparam int SH         = 59 - TABLE_BITS;
  localparam int XR_W       = SH - 26;
  localparam int ACC_W      = 35;

  localparam int MID_DEPTH  = 8;
  localparam int MID_AW     = $clog2(MID_DEPTH);
  localparam int MID_CW     = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH  = 16;
  localparam int OUT_AW     = $clog2(OUT_DEPTH);
  localparam int OUT_CW     = $clog2(OUT_DEPTH + 1);

  localparam logic [31:0] FOUR_OVER_PI_HI = 32'hA2F9836E;
  localparam logic [31:0] FOUR_OVER_PI_LO = 32'h4E441529;
  localparam logic [31:0] PI4_Q32         = 32'hC90FDAA2;
  localparam logic [39:0] PI4_Q40         = 40'hC90FDAA221;

  typedef logic signed [ACC_W-1:0] coef_t;
  typedef logic [31:0] tab_t [TAB_N];

  localparam coef_t SIN_COEF [MAX_TERMS] = '{
    coef_t'(0), coef_t'(64'sd4294967296), coef_t'(0), coef_t'(-64'sd715827883),
    coef_t'(0), coef_t'(64'sd35791394), coef_t'(0), coef_t'(-64'sd852176)
  };
  localparam coef_t COS_COEF [MAX_TERMS] = '{
    coef_t'(64'sd4294967296), coef_t'(0), coef_t'(-64'sd2147483648), coef_t'(0),
    coef_t'(64'sd178956971), coef_t'(0), coef_t'(-64'sd5965232), coef_t'(0)
  };

  localparam longint unsigned SIN_DIV [MAX_TERMS] = '{6, 20, 42, 72, 110, 156, 210, 272};
  localparam longint unsigned COS_DIV [MAX_TERMS] = '{2, 12, 30, 56, 90, 132, 182, 240};

  typedef struct packed {
    logic              tiny;
    logic [31:0]       tval;
    logic              sgn;
    logic              use_cos;
    logic [TABLE_BITS-1:0] idx;
    logic [XR_W-1:0]   xr;
  } stes_item_t;

  // Taylor series at a table point, evaluated at elaboration only
  function automatic tab_t build_tab(input bit cosine);
    tab_t              tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    for (int i = 0; i < TAB_N; i++) begin
      x    = (longint'(i) * longint'(PI4_Q40)) >> (TABLE_BITS + 8);
      x2   = (x * x + (64'd1 << 31)) >> 32;
      term = cosine ? (64'd1 << 32) : x;
      sum  = longint'(term);
      for (int k = 1; k <= MAX_TERMS; k++) begin
        if (cosine) begin
          term = ((term * x2 + (64'd1 << 31)) >> 32) / COS_DIV[k-1];
        end else begin
          term = ((term * x2 + (64'd1 << 31)) >> 32) / SIN_DIV[k-1];
        end
        if ((k % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(64'd1 << 32)) sum = longint'(64'd1 << 32);
      tab[i] = 32'((longint'(sum) + 1) >> 1);
    end
    return tab;
  endfunction

  localparam tab_t SIN_TAB = build_tab(1'b0);
  localparam tab_t COS_TAB = build_tab(1'b1);

endpackage

@@ sv/stes_front.sv @@
`timescale 1ns / 1ps
module stes_front import stes_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic signed [31:0] angle_i,
  output logic              valid_o,
  output stes_item_t        item_o,
  input  logic              pop_i
);

  logic acc_in;
  logic pop_ok;
  logic [MID_CW-1:0] occ_q, occ_d;

  logic v1_q, v2_q, v3_q;
  logic neg1_q, tiny1_q, neg2_q, tiny2_q;
  logic [31:0] mag1_q, tv1_q, tv2_q, tv3_q;
  logic [63:0] ph2_q;
  logic [31:0] plh2_q;
  logic [SH:0] d3_q;
  logic [TABLE_BITS-1:0] idx3_q;
  logic sgn3_q, usec3_q, tiny3_q;

  logic [31:0] mag;
  logic [63:0] pl;
  logic [63:0] p;
  logic s_b, q_b, h_b;
  logic [TABLE_BITS-1:0] t_b;
  logic [SH-1:0] frac;
  logic [SH:0] d;
  logic [XR_W+31:0] prod;
  stes_item_t wr_item;

  stes_item_t mem_q [MID_DEPTH];
  logic [MID_AW-1:0] wp_q, rp_q;
  logic [MID_CW-1:0] cnt_q;

  // occupancy counts items in flight plus queued, so the pipe never stalls
  assign full_o = (occ_q == MID_CW'(MID_DEPTH));
  assign acc_in = push_i && !full_o;
  assign valid_o = (cnt_q != '0);
  assign pop_ok = pop_i && valid_o;
  assign item_o = mem_q[rp_q];
  assign occ_d = occ_q + MID_CW'(acc_in) - MID_CW'(pop_ok);

  always_comb begin
    mag = angle_i[31] ? 32'(-angle_i) : angle_i;
    pl  = 64'(mag1_q) * 64'(FOUR_OVER_PI_LO);
    p   = ph2_q + {32'b0, plh2_q};
    s_b = p[SH+TABLE_BITS];
    q_b = p[SH+TABLE_BITS+1];
    h_b = p[SH+TABLE_BITS+2];
    t_b = p[SH+TABLE_BITS-1:SH];
    frac = p[SH-1:0];
    d = s_b ? ({1'b1, {SH{1'b0}}} - {1'b0, frac}) : {1'b0, frac};
    prod = (XR_W+32)'(d3_q[SH:27]) * (XR_W+32)'(PI4_Q32);
    wr_item.tiny    = tiny3_q;
    wr_item.tval    = tv3_q;
    wr_item.sgn     = sgn3_q;
    wr_item.use_cos = usec3_q;
    wr_item.idx     = idx3_q;
    wr_item.xr      = prod[XR_W+31:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      occ_q <= '0;
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      v1_q  <= acc_in;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      occ_q <= occ_d;
      if (v3_q) wp_q <= wp_q + 1'b1;
      if (pop_ok) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + MID_CW'(v3_q) - MID_CW'(pop_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q  <= angle_i[31];
    tiny1_q <= (mag < 32'd2);
    mag1_q  <= mag;
    tv1_q   <= angle_i << 2;
    ph2_q   <= 64'(mag1_q) * 64'(FOUR_OVER_PI_HI);
    plh2_q  <= pl[63:32];
    neg2_q  <= neg1_q;
    tiny2_q <= tiny1_q;
    tv2_q   <= tv1_q;
    d3_q    <= d;
    idx3_q  <= s_b ? ~t_b : t_b;
    sgn3_q  <= neg2_q ^ h_b;
    usec3_q <= q_b ^ s_b;
    tiny3_q <= tiny2_q;
    tv3_q   <= tv2_q;
    if (v3_q) mem_q[wp_q] <= wr_item;
  end

endmodule

@@ sv/stes_back.sv @@
`timescale 1ns / 1ps
module stes_back import stes_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  stes_item_t        item_i,
  output logic              pop_o,
  output logic              empty_o,
  output logic signed [31:0] sine_o,
  input  logic              pop_i
);

  localparam int NST = POLY_TERMS - 1;

  typedef struct packed {
    logic              tiny;
    logic [31:0]       tval;
    logic              sgn;
    logic              use_cos;
    logic [31:0]       sa;
    logic [31:0]       ca;
    logic [XR_W-1:0]   xr;
    logic signed [ACC_W-1:0] acc_s;
    logic signed [ACC_W-1:0] acc_c;
  } hst_t;

  function automatic logic signed [ACC_W-1:0] mul_round(
    input logic signed [ACC_W-1:0] v,
    input logic [XR_W-1:0] x
  );
    logic                neg;
    logic [ACC_W-2:0]    m;
    logic [ACC_W+XR_W-2:0] pr;
    logic [ACC_W+XR_W-2:0] r;
    neg = v[ACC_W-1];
    m   = neg ? (ACC_W-1)'(-v) : v[ACC_W-2:0];
    pr  = (ACC_W+XR_W-1)'(m) * (ACC_W+XR_W-1)'(x);
    r   = (pr + (ACC_W+XR_W-1)'(64'd1 << 31)) >> 32;
    return neg ? -ACC_W'(r) : ACC_W'(r);
  endfunction

  function automatic logic [32:0] clamp_q32(input logic signed [ACC_W-1:0] v);
    if (v < 0) return 33'd0;
    if (v > ACC_W'(64'd1 << 32)) return 33'h1_0000_0000;
    return v[32:0];
  endfunction

  hst_t hst_q [NST];
  logic hv_q  [NST];
  hst_t h0;

  logic [OUT_CW-1:0] occ_q;
  logic pv_q, sv_q;
  logic [64:0] pa_q, pb_q, sum_q;
  logic psgn_q, pusec_q, ptiny_q, ssgn_q, stiny_q;
  logic [31:0] ptv_q, stv_q;
  logic [32:0] sd, cd;
  logic [64:0] sum;
  logic [64:0] yr;
  logic [31:0] y, res;

  logic [31:0] mem_q [OUT_DEPTH];
  logic [OUT_AW-1:0] wp_q, rp_q;
  logic [OUT_CW-1:0] cnt_q;
  logic out_ok;

  // issue only with a free slot reserved in the result queue
  assign pop_o   = valid_i && (occ_q < OUT_CW'(OUT_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign out_ok  = pop_i && !empty_o;
  assign sine_o  = mem_q[rp_q];

  always_comb begin
    h0.tiny    = item_i.tiny;
    h0.tval    = item_i.tval;
    h0.sgn     = item_i.sgn;
    h0.use_cos = item_i.use_cos;
    h0.sa      = SIN_TAB[item_i.idx];
    h0.ca      = COS_TAB[item_i.idx];
    h0.xr      = item_i.xr;
    h0.acc_s   = SIN_COEF[POLY_TERMS-1];
    h0.acc_c   = COS_COEF[POLY_TERMS-1];
  end

  genvar j;
  for (j = 0; j < NST; j++) begin : g_horner
    localparam int K = POLY_TERMS - 2 - j;
    hst_t hin, hout;
    logic vin;
    if (j == 0) begin : g_first
      assign hin = h0;
      assign vin = pop_o;
    end else begin : g_next
      assign hin = hst_q[j-1];
      assign vin = hv_q[j-1];
    end
    always_comb begin
      hout       = hin;
      hout.acc_s = SIN_COEF[K] + mul_round(hin.acc_s, hin.xr);
      hout.acc_c = COS_COEF[K] + mul_round(hin.acc_c, hin.xr);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hv_q[j] <= 1'b0;
      end else begin
        hv_q[j] <= vin;
      end
    end
    always_ff @(posedge clk_i) begin
      hst_q[j] <= hout;
    end
  end

  always_comb begin
    sd  = clamp_q32(hst_q[NST-1].acc_s);
    cd  = clamp_q32(hst_q[NST-1].acc_c);
    if (pusec_q) sum = (pa_q > pb_q) ? (pa_q - pb_q) : 65'd0;
    else sum = pa_q + pb_q;
    yr  = (sum_q + 65'h1_0000_0000) >> 33;
    y   = (yr > 65'h4000_0000) ? 32'h4000_0000 : yr[31:0];
    res = stiny_q ? stv_q : (ssgn_q ? -y : y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      sv_q  <= 1'b0;
      occ_q <= '0;
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      pv_q  <= hv_q[NST-1];
      sv_q  <= pv_q;
      occ_q <= occ_q + OUT_CW'(pop_o) - OUT_CW'(out_ok);
      if (sv_q) wp_q <= wp_q + 1'b1;
      if (out_ok) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + OUT_CW'(sv_q) - OUT_CW'(out_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (hst_q[NST-1].use_cos) begin
      pa_q <= 65'(hst_q[NST-1].ca) * 65'(cd);
      pb_q <= 65'(hst_q[NST-1].sa) * 65'(sd);
    end else begin
      pa_q <= 65'(hst_q[NST-1].sa) * 65'(cd);
      pb_q <= 65'(hst_q[NST-1].ca) * 65'(sd);
    end
    psgn_q  <= hst_q[NST-1].sgn;
    pusec_q <= hst_q[NST-1].use_cos;
    ptiny_q <= hst_q[NST-1].tiny;
    ptv_q   <= hst_q[NST-1].tval;
    sum_q   <= sum;
    ssgn_q  <= psgn_q;
    stiny_q <= ptiny_q;
    stv_q   <= ptv_q;
    if (sv_q) mem_q[wp_q] <= res;
  end

endmodule

@@ sv/sine_table_poly_eval_core.sv @@
`timescale 1ns / 1ps
// Sine of a Q4.28 angle in radians, returned as Q2.30.
// Input channel: drive angle_i and push_i; a transfer happens on a clock
// edge with push_i high and full_o low. Output channel: while empty_o is
// low the oldest result sits on sine_o; pop_i high at an edge takes it.
// Unless stalled, one angle enters and one result leaves every cycle.
// From input transfer to empty_o falling, an angle passes range reduction
// (4/pi scaling, then the residual scaled by pi/4 and written to the middle
// queue), POLY_TERMS-1 Horner steps, the first reading the middle queue in
// the same cycle, one product stage for the angle-addition rule, one sum
// stage, then the result queue write.
// The front side stalls only when its queue and pipe together hold
// MID_DEPTH items; the back side issues only with a free slot in the
// result queue, so a stalled receiver fills that queue, then the middle
// queue, and then raises full_o. Nothing is dropped.
// Reset empties both queues and clears all valid flags; no item is in
// flight afterwards and full_o is low.
module sine_table_poly_eval_core import stes_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic signed [31:0] angle_i,
  output logic              empty_o,
  input  logic              pop_i,
  output logic signed [31:0] sine_o
);

  logic       mid_valid;
  logic       mid_pop;
  stes_item_t mid_item;

  stes_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .full_o  (full_o),
    .angle_i (angle_i),
    .valid_o (mid_valid),
    .item_o  (mid_item),
    .pop_i   (mid_pop)
  );

  stes_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .item_i  (mid_item),
    .pop_o   (mid_pop),
    .empty_o (empty_o),
    .sine_o  (sine_o),
    .pop_i   (pop_i)
  );

endmodule

@@ tb/sine_table_poly_eval_core_tb.sv @@
`timescale 1ns / 1ps
module sine_table_poly_eval_core_tb;
  import stes_pkg::*;

  localparam longint unsigned ONE_Q32 = 64'd1 << 32;
  localparam int LIMIT_CYCLES = 400000;
  localparam int NUM_RANDOM = 1600;

  // Taylor coefficients of sin and cos of a small residual, Q32
  localparam longint RES_SIN_C [8] = '{
    64'sd0, 64'sd4294967296, 64'sd0, -64'sd715827883,
    64'sd0, 64'sd35791394, 64'sd0, -64'sd852176
  };
  localparam longint RES_COS_C [8] = '{
    64'sd4294967296, 64'sd0, -64'sd2147483648, 64'sd0,
    64'sd178956971, 64'sd0, -64'sd5965232, 64'sd0
  };

  // signed Q32 times unsigned Q32, rounded half away from zero
  function automatic longint q32_mul(longint v, longint unsigned x);
    longint unsigned m;
    longint unsigned r;
    m = (v < 0) ? (64'd0 - longint'(v)) : longint'(v);
    r = (m * x + (64'd1 << 31)) >> 32;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned residual_poly(bit cosine, longint unsigned x);
    longint acc;
    acc = cosine ? RES_COS_C[POLY_TERMS-1] : RES_SIN_C[POLY_TERMS-1];
    for (int k = POLY_TERMS - 2; k >= 0; k--)
      acc = (cosine ? RES_COS_C[k] : RES_SIN_C[k]) + q32_mul(acc, x);
    if (acc < 0) return 0;
    if (longint'(acc) > longint'(ONE_Q32)) return ONE_Q32;
    return acc;
  endfunction

  function automatic longint unsigned table_point(longint unsigned x, bit cosine);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned n;
    longint sum;
    x2 = (x * x + (64'd1 << 31)) >> 32;
    term = cosine ? ONE_Q32 : x;
    sum = term;
    for (int k = 1; k <= 8; k++) begin
      n = cosine ? 2 * k - 1 : 2 * k;
      term = ((term * x2 + (64'd1 << 31)) >> 32) / (n * (n + 1));
      if (k % 2) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q32)) sum = ONE_Q32;
    return (longint'(sum) + 1) >> 1;
  endfunction

  function automatic logic signed [31:0] predict_sine(logic signed [31:0] angle);
    longint unsigned raw, mag, p, oct, frac, t, idx, d, xr, ta, sa, ca, sd, cd, sum, y;
    longint unsigned p1, p2;
    bit neg, s, q, h;
    raw = {32'd0, angle};
    neg = angle[31];
    mag = neg ? (ONE_Q32 - raw) : raw;
    if (mag < 2) return 32'(raw * 4);
    p = mag * 64'hA2F9836E + ((mag * 64'h4E441529) >> 32);
    oct = p >> SH;
    frac = p & ((64'd1 << SH) - 1);
    s = oct[TABLE_BITS];
    q = oct[TABLE_BITS+1];
    h = oct[TABLE_BITS+2];
    t = oct & (TAB_N - 1);
    idx = s ? (TAB_N - 1 - t) : t;
    d = s ? ((64'd1 << SH) - frac) : frac;
    xr = ((d >> 27) * 64'hC90FDAA2) >> 32;
    ta = (idx * 64'hC90FDAA221) >> (TABLE_BITS + 8);
    sa = table_point(ta, 1'b0);
    ca = table_point(ta, 1'b1);
    sd = residual_poly(1'b0, xr);
    cd = residual_poly(1'b1, xr);
    if (!(q ^ s)) sum = sa * cd + ca * sd;
    else begin
      p1 = ca * cd;
      p2 = sa * sd;
      sum = (p1 > p2) ? p1 - p2 : 0;
    end
    y = (sum + ONE_Q32) >> 33;
    if (y > (64'd1 << 30)) y = 64'd1 << 30;
    return (neg ^ h) ? 32'(ONE_Q32 - y) : 32'(y);
  endfunction

  class sine_scoreboard;
    logic signed [31:0] pending_sines[$];
    int errors;

    function void note_angle(logic signed [31:0] angle);
      pending_sines.push_back(predict_sine(angle));
    endfunction

    function void check_sine(logic signed [31:0] sine);
      logic signed [31:0] want;
      if (pending_sines.size() == 0) begin
        $error("unexpected result sine=%0d", sine);
        errors++;
      end else begin
        want = pending_sines.pop_front();
        if (sine !== want) begin
          $error("field sine: expected %0d actual %0d", want, sine);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_i = 1'b0;
  logic pop_i = 1'b0;
  logic signed [31:0] angle_i = '0;
  logic full_o, empty_o;
  logic signed [31:0] sine_o;
  logic stim_done = 1'b0;
  int cycle_cnt = 0;
  sine_scoreboard sb = new();

  sine_table_poly_eval_core dut (
    .clk_i, .rst_ni, .push_i, .full_o, .angle_i, .empty_o, .pop_i, .sine_o
  );

  always #10 clk_i = ~clk_i;

  // sample both channels at the edge before any driver update lands
  always @(posedge clk_i) begin
    if (rst_ni && push_i && !full_o) sb.note_angle(angle_i);
    if (rst_ni && pop_i && !empty_o) sb.check_sine(sine_o);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stall pattern: alternate free runs and random stall stretches
  int pop_phase = 0;
  always @(posedge clk_i) begin
    pop_phase <= (pop_phase + 1) % 400;
    if (pop_phase < 120) pop_i <= 1'b1;
    else if (pop_phase < 250) pop_i <= ($urandom_range(0, 3) != 0);
    else pop_i <= ($urandom_range(0, 2) == 0);
  end

  // hold push until the transfer completes
  task automatic send_angle(logic signed [31:0] angle);
    push_i <= 1'b1;
    angle_i <= angle;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      push_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [31:0] random_angle();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 7) - 4;
      1: return $urandom_range(0, 32'h3243F6A9);
      2: return -$signed($urandom_range(0, 32'h3243F6A9));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [31:0] directed [$];
    int burst;
    directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd2, -32'sd2, 32'h7FFFFFFF,
                 32'h80000000, 32'h80000001, 32'h3243F6A9, 32'h1921FB54,
                 -32'sh1921FB54, 32'hC90FDAA, 32'h6487ED51, 32'h4B65F1FD,
                 32'h55555555, 32'hAAAAAAAA, 32'h0000FFFF, 32'hFFFF0000,
                 32'h12D97C7F, 32'h10000000};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_angle(directed[i]);
    idle_gap(3);
    for (int n = 0; n < NUM_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++, n++) send_angle(random_angle());
      idle_gap($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 12));
    end
    push_i <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending_sines.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_sines.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
